@@ src/imp2x2_pkg.sv @@
// int8 2x2 max pooling: shared widths, types, register indexes and reset values
// no dependencies
package imp2x2_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 10;
    localparam int CHAN_W    = 8;
    localparam int DIM_W     = 11;
    localparam int NCH_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_W     = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [WIN_W-1:0]           t_win_mask;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_MODE     = 3'd0,
        CFG_FRAME_WIDTH   = 3'd1,
        CFG_FRAME_HEIGHT  = 3'd2,
        CFG_CHANNEL_COUNT = 3'd3
    } t_cfg_idx;

    localparam logic             MODE_STRIDE1 = 1'b0;
    localparam logic             MODE_STRIDE2 = 1'b1;

    localparam logic             RST_POOL_MODE     = MODE_STRIDE2;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 11'd26;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 11'd26;
    localparam logic [NCH_W-1:0] RST_CHANNEL_COUNT = 9'd256;

    localparam logic [DIM_W-1:0] MAX_DIM      = 11'd1024;
    localparam logic [NCH_W-1:0] MAX_NCH      = 9'd256;
    localparam int               PROD_W       = DIM_W + NCH_W;

endpackage

@@ src/int8_max_pool_2x2.sv @@
// int8 2x2 max pooling top level: line store, left-neighbour stores and result register
// depends on imp2x2_pkg
//
// Streams signed 8-bit feature values (raster order, channels innermost) and
// gives 2x2 window maxima tagged with row, column and channel. Stride-two mode
// and interior positions of stride-one mode take one input transaction per cycle
// while the output is not stalled. In stride-one mode a sample in the last column
// or last row closes up to four windows; the input is stalled until the last of its
// results can leave, as all results leave through a single output register.
// Results pass through the window stage and then the result register. The line
// store and the current-row left store are single-port read-first memories written
// at input acceptance; the upper-row left store is written in the following cycle
// from the line store read, with a bypass when the same channel follows at once.
// No clearing pass is needed after reset. Any write to a defined register restarts
// the frame; with an unusable geometry every input is taken and dropped.
module int8_max_pool_2x2 #(
    parameter int LINE_DEPTH   = 8192,
    parameter int MAX_CHANNELS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [imp2x2_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [imp2x2_pkg::SAMPLE_W-1:0] o_pooled_value,
    output logic [imp2x2_pkg::ROW_W-1:0]        o_out_row,
    output logic [imp2x2_pkg::COL_W-1:0]        o_out_col,
    output logic [imp2x2_pkg::CHAN_W-1:0]       o_out_channel,
    output logic                                o_run_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imp2x2_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imp2x2_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LA_W     = $clog2(LINE_DEPTH);
    localparam int LC_DEPTH = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
    localparam int CH_AW    = (LC_DEPTH > 1) ? $clog2(LC_DEPTH) : 1;
    localparam logic [imp2x2_pkg::PROD_W-1:0] LINE_LIM = imp2x2_pkg::PROD_W'(LINE_DEPTH);
    localparam logic [imp2x2_pkg::DIM_W-1:0]  CH_LIM   = imp2x2_pkg::DIM_W'(MAX_CHANNELS);

    // configuration
    logic                               r_mode;
    logic [imp2x2_pkg::DIM_W-1:0]       r_width;
    logic [imp2x2_pkg::DIM_W-1:0]       r_height;
    logic [imp2x2_pkg::NCH_W-1:0]       r_nch;

    // position counters
    logic [imp2x2_pkg::ROW_W-1:0]       r_row;
    logic [imp2x2_pkg::COL_W-1:0]       r_col;
    logic [imp2x2_pkg::CHAN_W-1:0]      r_chan;
    logic [LA_W-1:0]                    r_addr;

    // memories
    imp2x2_pkg::t_sample                line_mem  [0:LINE_DEPTH-1];
    imp2x2_pkg::t_sample                lcur_mem  [0:LC_DEPTH-1];
    imp2x2_pkg::t_sample                lup_mem   [0:LC_DEPTH-1];

    // left-upper write-back of the previous transaction
    logic                               r_lu_wr;
    logic [CH_AW-1:0]                   r_lu_ch;

    // window stage
    imp2x2_pkg::t_win_mask              r_s1_mask;
    imp2x2_pkg::t_sample                r_cur;
    imp2x2_pkg::t_sample                r_up;
    imp2x2_pkg::t_sample                r_lc;
    imp2x2_pkg::t_sample                r_ul;
    logic [imp2x2_pkg::ROW_W-1:0]       r_row_a;
    logic [imp2x2_pkg::ROW_W-1:0]       r_row_b;
    logic [imp2x2_pkg::COL_W-1:0]       r_col_a;
    logic [imp2x2_pkg::COL_W-1:0]       r_col_b;
    logic [imp2x2_pkg::CHAN_W-1:0]      r_s1_ch;

    // result register
    logic                               r_out_valid;
    imp2x2_pkg::t_sample                r_out_val;
    logic [imp2x2_pkg::ROW_W-1:0]       r_out_row;
    logic [imp2x2_pkg::COL_W-1:0]       r_out_col;
    logic [imp2x2_pkg::CHAN_W-1:0]      r_out_ch;
    logic                               r_out_last;

    logic                               cfg_wr;
    logic                               geom_ok;
    logic [imp2x2_pkg::PROD_W-1:0]      line_len;
    logic                               in_acc;
    logic                               take;
    logic [CH_AW-1:0]                   ch_idx;
    logic                               col_last;
    logic                               row_last;
    logic                               chan_last;
    imp2x2_pkg::t_win_mask              n_mask;
    logic [imp2x2_pkg::ROW_W-1:0]       n_row_a;
    logic [imp2x2_pkg::ROW_W-1:0]       n_row_b;
    logic [imp2x2_pkg::COL_W-1:0]       n_col_a;
    logic [imp2x2_pkg::COL_W-1:0]       n_col_b;
    logic                               out_free;
    imp2x2_pkg::t_win_mask              low_bit;
    imp2x2_pkg::t_win_mask              rem_mask;
    logic                               pop;
    imp2x2_pkg::t_sample                m_top;
    imp2x2_pkg::t_sample                m_bot;
    imp2x2_pkg::t_sample                m_all;
    imp2x2_pkg::t_sample                m_right;
    imp2x2_pkg::t_sample                n_out_val;
    logic [imp2x2_pkg::ROW_W-1:0]       n_out_row;
    logic [imp2x2_pkg::COL_W-1:0]       n_out_col;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign line_len = imp2x2_pkg::PROD_W'(r_width) * imp2x2_pkg::PROD_W'(r_nch);
    assign geom_ok  = (r_width != '0) && (r_width <= imp2x2_pkg::MAX_DIM)
                   && (r_height != '0) && (r_height <= imp2x2_pkg::MAX_DIM)
                   && (r_nch != '0) && (r_nch <= imp2x2_pkg::MAX_NCH)
                   && ({2'b00, r_nch} <= CH_LIM)
                   && (line_len <= LINE_LIM);

    assign in_acc = i_in_valid && !o_in_stall;
    assign take   = in_acc && geom_ok;
    assign ch_idx = r_chan[CH_AW-1:0];

    assign col_last  = ({1'b0, r_col} == (r_width - 11'd1));
    assign row_last  = ({1'b0, r_row} == (r_height - 11'd1));
    assign chan_last = (({1'b0, r_chan} + 9'd1) >= r_nch);

    // windows closed by the incoming sample, in raster order
    always_comb begin
        n_mask  = '0;
        n_row_a = r_row - 10'd1;
        n_row_b = r_row;
        n_col_a = r_col - 10'd1;
        n_col_b = r_col;
        if (r_mode == imp2x2_pkg::MODE_STRIDE1) begin
            n_mask[0] = (r_row != '0) && (r_col != '0);
            n_mask[1] = (r_row != '0) && col_last;
            n_mask[2] = row_last && (r_col != '0);
            n_mask[3] = row_last && col_last;
        end else begin
            n_mask[0] = r_row[0] && r_col[0];
            n_row_a   = {1'b0, r_row[imp2x2_pkg::ROW_W-1:1]};
            n_col_a   = {1'b0, r_col[imp2x2_pkg::COL_W-1:1]};
        end
    end

    // result selection
    assign out_free = !r_out_valid || !i_out_stall;
    assign low_bit  = r_s1_mask & (~r_s1_mask + 4'd1);
    assign rem_mask = r_s1_mask & ~low_bit;
    assign pop      = out_free && (r_s1_mask != '0);
    assign o_in_stall = (r_s1_mask != '0) && !(out_free && (rem_mask == '0));

    assign m_top   = (r_ul > r_up)  ? r_ul  : r_up;
    assign m_bot   = (r_lc > r_cur) ? r_lc  : r_cur;
    assign m_all   = (m_top > m_bot) ? m_top : m_bot;
    assign m_right = (r_up > r_cur) ? r_up  : r_cur;

    always_comb begin
        priority if (low_bit[0]) begin
            n_out_val = m_all;
            n_out_row = r_row_a;
            n_out_col = r_col_a;
        end else if (low_bit[1]) begin
            n_out_val = m_right;
            n_out_row = r_row_a;
            n_out_col = r_col_b;
        end else if (low_bit[2]) begin
            n_out_val = m_bot;
            n_out_row = r_row_b;
            n_out_col = r_col_a;
        end else begin
            n_out_val = r_cur;
            n_out_row = r_row_b;
            n_out_col = r_col_b;
        end
    end

    // memories, read-first
    always_ff @(posedge i_clk) begin
        if (take) begin
            line_mem[r_addr] <= i_sample_value;
            r_up             <= line_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            lcur_mem[ch_idx] <= i_sample_value;
            r_lc             <= lcur_mem[ch_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_lu_wr) begin
            lup_mem[r_lu_ch] <= r_up;
        end
        if (take) begin
            if (r_lu_wr && (r_lu_ch == ch_idx)) begin
                r_ul <= r_up;
            end else begin
                r_ul <= lup_mem[ch_idx];
            end
        end
    end

    // window stage and result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur   <= i_sample_value;
            r_row_a <= n_row_a;
            r_row_b <= n_row_b;
            r_col_a <= n_col_a;
            r_col_b <= n_col_b;
            r_s1_ch <= r_chan;
            r_lu_ch <= ch_idx;
        end
        if (pop) begin
            r_out_val  <= n_out_val;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_ch   <= r_s1_ch;
            r_out_last <= (rem_mask == '0);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= imp2x2_pkg::RST_POOL_MODE;
            r_width     <= imp2x2_pkg::RST_FRAME_WIDTH;
            r_height    <= imp2x2_pkg::RST_FRAME_HEIGHT;
            r_nch       <= imp2x2_pkg::RST_CHANNEL_COUNT;
            r_row       <= '0;
            r_col       <= '0;
            r_chan      <= '0;
            r_addr      <= '0;
            r_lu_wr     <= 1'b0;
            r_s1_mask   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lu_wr <= take;

            if (in_acc) begin
                r_s1_mask <= geom_ok ? n_mask : '0;
            end else if (pop) begin
                r_s1_mask <= rem_mask;
            end

            if (out_free) begin
                r_out_valid <= pop;
            end

            if (cfg_wr && (i_cfg_index <= imp2x2_pkg::CFG_CHANNEL_COUNT)) begin
                unique case (imp2x2_pkg::t_cfg_idx'(i_cfg_index))
                    imp2x2_pkg::CFG_POOL_MODE:     r_mode   <= i_cfg_data[0];
                    imp2x2_pkg::CFG_FRAME_WIDTH:   r_width  <= i_cfg_data;
                    imp2x2_pkg::CFG_FRAME_HEIGHT:  r_height <= i_cfg_data;
                    imp2x2_pkg::CFG_CHANNEL_COUNT: r_nch    <= i_cfg_data[imp2x2_pkg::NCH_W-1:0];
                    default: ;
                endcase
                r_row  <= '0;
                r_col  <= '0;
                r_chan <= '0;
                r_addr <= '0;
            end else if (take) begin
                if (chan_last) begin
                    r_chan <= '0;
                    if (({1'b0, r_col} + 11'd1) >= r_width) begin
                        r_col  <= '0;
                        r_addr <= '0;
                        r_row  <= (({1'b0, r_row} + 11'd1) >= r_height) ? '0 : r_row + 10'd1;
                    end else begin
                        r_col  <= r_col + 10'd1;
                        r_addr <= r_addr + 1'b1;
                    end
                end else begin
                    r_chan <= r_chan + 8'd1;
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_val;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_out_channel  = r_out_ch;
    assign o_run_last     = r_out_last;

    // checks
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        geom_ok |-> ({1'b0, r_col} < r_width) && ({1'b0, r_row} < r_height)
                 && ({1'b0, r_chan} < r_nch))
        else $error("position counters outside the frame");

    a_stride2_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == imp2x2_pkg::MODE_STRIDE2) |-> $onehot0(r_s1_mask))
        else $error("stride-two transaction closed more than one window");

    a_multi_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_s1_mask) > 1) |-> o_in_stall)
        else $error("input taken while several results are still pending");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_s1_mask != '0))
        else $error("result run ended without its last flag");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// testbench for int8_max_pool_2x2: directed and random feature frames, checked per transaction
// against a scoreboard class that predicts every pooled window; depends on imp2x2_pkg and the dut
module tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int STORE_DEPTH   = 8192;
    localparam int CHAN_LIMIT    = 256;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int STUCK_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 165;
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_LIGHT    = 26;
    localparam int IDLE_HEAVY    = 66;
    localparam logic [imp2x2_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 3'd4;
    localparam logic [imp2x2_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [imp2x2_pkg::SAMPLE_W-1:0] value;
        logic [imp2x2_pkg::ROW_W-1:0]           row;
        logic [imp2x2_pkg::COL_W-1:0]           col;
        logic [imp2x2_pkg::CHAN_W-1:0]          chan;
        logic                                   last;
    } t_pooled;

    class t_pool_scoreboard;
        logic                            mode;
        int unsigned                     width;
        int unsigned                     height;
        int unsigned                     nch;
        logic [imp2x2_pkg::SAMPLE_W-1:0] line_mem [STORE_DEPTH];
        logic [imp2x2_pkg::SAMPLE_W-1:0] left_cur [CHAN_LIMIT];
        logic [imp2x2_pkg::SAMPLE_W-1:0] left_up  [CHAN_LIMIT];
        int unsigned                     row;
        int unsigned                     col;
        int unsigned                     chan;
        t_pooled                         pooled_due[$];
        int unsigned                     errors;

        function new();
            mode   = imp2x2_pkg::RST_POOL_MODE;
            width  = 32'(imp2x2_pkg::RST_FRAME_WIDTH);
            height = 32'(imp2x2_pkg::RST_FRAME_HEIGHT);
            nch    = 32'(imp2x2_pkg::RST_CHANNEL_COUNT);
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (left_cur[i]) begin
                left_cur[i] = '0;
                left_up[i]  = '0;
            end
            row    = 0;
            col    = 0;
            chan   = 0;
            errors = 0;
        endfunction

        function bit geometry_valid();
            return width >= 1 && width <= imp2x2_pkg::MAX_DIM
                && height >= 1 && height <= imp2x2_pkg::MAX_DIM
                && nch >= 1 && nch <= imp2x2_pkg::MAX_NCH && nch <= CHAN_LIMIT
                && width * nch <= STORE_DEPTH;
        endfunction

        function void note_config(logic [imp2x2_pkg::CFG_IDX_W-1:0] idx,
                                  logic [imp2x2_pkg::CFG_DATA_W-1:0] data);
            unique case (idx)
                imp2x2_pkg::CFG_POOL_MODE:     mode   = data[0];
                imp2x2_pkg::CFG_FRAME_WIDTH:   width  = 32'(data);
                imp2x2_pkg::CFG_FRAME_HEIGHT:  height = 32'(data);
                imp2x2_pkg::CFG_CHANNEL_COUNT: nch    = 32'(data[imp2x2_pkg::NCH_W-1:0]);
                default:                       return;
            endcase
            row  = 0;
            col  = 0;
            chan = 0;
        endfunction

        function imp2x2_pkg::t_sample maxs(imp2x2_pkg::t_sample a, imp2x2_pkg::t_sample b);
            return (a > b) ? a : b;
        endfunction

        function t_pooled window(imp2x2_pkg::t_sample v, int unsigned r, int unsigned c);
            t_pooled p;
            p.value = v;
            p.row   = imp2x2_pkg::ROW_W'(r);
            p.col   = imp2x2_pkg::COL_W'(c);
            p.chan  = imp2x2_pkg::CHAN_W'(chan);
            p.last  = 1'b0;
            return p;
        endfunction

        // predicts the windows closed by one accepted sample
        function void take_sample(imp2x2_pkg::t_sample v);
            int unsigned         idx;
            imp2x2_pkg::t_sample up;
            imp2x2_pkg::t_sample ul;
            imp2x2_pkg::t_sample lc;
            t_pooled             fresh[$];
            t_pooled             p;
            if (!geometry_valid()) return;
            idx = col * nch + chan;
            up  = line_mem[idx];
            ul  = left_up[chan];
            lc  = left_cur[chan];
            if (mode == imp2x2_pkg::MODE_STRIDE1) begin
                if (row >= 1 && col >= 1)
                    fresh.push_back(window(maxs(maxs(ul, up), maxs(lc, v)), row - 1, col - 1));
                if (row >= 1 && col == width - 1)
                    fresh.push_back(window(maxs(up, v), row - 1, col));
                if (row == height - 1 && col >= 1)
                    fresh.push_back(window(maxs(lc, v), row, col - 1));
                if (row == height - 1 && col == width - 1)
                    fresh.push_back(window(v, row, col));
            end else if ((row % 2) == 1 && (col % 2) == 1) begin
                fresh.push_back(window(maxs(maxs(ul, up), maxs(lc, v)), row / 2, col / 2));
            end
            if (fresh.size() > 0) begin
                p = fresh.pop_back();
                p.last = 1'b1;
                fresh.push_back(p);
            end
            foreach (fresh[i]) pooled_due.push_back(fresh[i]);
            left_up[chan]  = line_mem[idx];
            left_cur[chan] = v;
            line_mem[idx]  = v;
            if (chan + 1 >= nch) begin
                chan = 0;
                if (col + 1 >= width) begin
                    col = 0;
                    row = (row + 1 >= height) ? 0 : row + 1;
                end else begin
                    col++;
                end
            end else begin
                chan++;
            end
        endfunction

        function void check_pooled(t_pooled got);
            t_pooled want;
            if (pooled_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: value %0d row %0d col %0d ch %0d last %0b",
                             $signed(got.value), got.row, got.col, got.chan, got.last);
                return;
            end
            want = pooled_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch: expected value %0d row %0d col %0d ch %0d last %0b",
                             $signed(want.value), want.row, want.col, want.chan, want.last);
                    $display("          actual   value %0d row %0d col %0d ch %0d last %0b",
                             $signed(got.value), got.row, got.col, got.chan, got.last);
                end
            end
        endfunction
    endclass

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n;
    logic                                    i_in_valid;
    logic                                    o_in_stall;
    imp2x2_pkg::t_sample                     i_sample_value;
    logic                                    o_out_valid;
    logic                                    i_out_stall;
    imp2x2_pkg::t_sample                     o_pooled_value;
    logic [imp2x2_pkg::ROW_W-1:0]            o_out_row;
    logic [imp2x2_pkg::COL_W-1:0]            o_out_col;
    logic [imp2x2_pkg::CHAN_W-1:0]           o_out_channel;
    logic                                    o_run_last;
    logic                                    i_cfg_valid;
    logic                                    o_cfg_ready;
    logic [imp2x2_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [imp2x2_pkg::CFG_DATA_W-1:0]       i_cfg_data;

    t_pool_scoreboard sb = new();
    int unsigned      snd_idle_pct = IDLE_LIGHT;
    int unsigned      rcv_idle_pct = IDLE_HEAVY;
    int unsigned      hold_requests = 0;
    int unsigned      random_items = 0;
    int unsigned      stuck_cycles = 0;

    int8_max_pool_2x2 #(
        .LINE_DEPTH  (STORE_DEPTH),
        .MAX_CHANNELS(CHAN_LIMIT)
    ) i_dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : receiver
        int unsigned hold_served;
        int unsigned hold_left;
        t_pooled     got;
        hold_served = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = {o_pooled_value, o_out_row, o_out_col, o_out_channel, o_run_last};
                sb.check_pooled(got);
            end
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    function automatic imp2x2_pkg::t_sample random_sample();
        unique case ($urandom_range(7))
            0:       return -8'sd128;
            1:       return 8'sd127;
            default: return imp2x2_pkg::t_sample'($urandom_range(255));
        endcase
    endfunction

    task automatic send_sample(input imp2x2_pkg::t_sample v);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.take_sample(v);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pooled_due.size() != 0);
    endtask

    // block idle: all results in and the pipeline empty
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [imp2x2_pkg::CFG_IDX_W-1:0] idx,
                             input logic [imp2x2_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.note_config(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic m, input int unsigned w, input int unsigned h,
                                  input int unsigned nc);
        write_reg(imp2x2_pkg::CFG_POOL_MODE, {(imp2x2_pkg::CFG_DATA_W-1)'($urandom), m});
        write_reg(imp2x2_pkg::CFG_FRAME_WIDTH, imp2x2_pkg::DIM_W'(w));
        write_reg(imp2x2_pkg::CFG_FRAME_HEIGHT, imp2x2_pkg::DIM_W'(h));
        write_reg(imp2x2_pkg::CFG_CHANNEL_COUNT,
                  {(imp2x2_pkg::CFG_DATA_W-imp2x2_pkg::NCH_W)'($urandom),
                   imp2x2_pkg::NCH_W'(nc)});
    endtask

    task automatic write_unused_reg();
        write_reg(imp2x2_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_HI, CFG_IDX_UNUSED_LO)),
                  imp2x2_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic run_samples(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                snd_idle_pct = IDLE_LIGHT;
                rcv_idle_pct = IDLE_HEAVY;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = IDLE_HEAVY;
                rcv_idle_pct = IDLE_LIGHT;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if (sb.geometry_valid()) random_items++;
            send_sample(random_sample());
        end
    endtask

    initial begin : stimulus
        imp2x2_pkg::t_sample corner_frame[4] = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1};
        imp2x2_pkg::t_sample wrap_frame[4]   = '{8'sd127, -8'sd128, -8'sd128, -8'sd128};
        logic        m;
        int unsigned w;
        int unsigned h;
        int unsigned nc;
        int unsigned n;
        int unsigned pick;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_value = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: first row of a stride-two frame, nothing comes out
        repeat (3) send_sample(random_sample());
        settle();

        // 2x2 frame, the last sample closes four windows, then a wrap into the next frame
        write_geometry(imp2x2_pkg::MODE_STRIDE1, 2, 2, 1);
        foreach (corner_frame[i]) send_sample(corner_frame[i]);
        foreach (wrap_frame[i]) send_sample(wrap_frame[i]);

        // write to an unused index mid-frame leaves the frame position alone
        send_sample(random_sample());
        send_sample(random_sample());
        settle();
        write_unused_reg();
        send_sample(random_sample());
        send_sample(random_sample());
        settle();

        // stride two with trailing odd row and column
        write_geometry(imp2x2_pkg::MODE_STRIDE2, 3, 3, 1);
        repeat (9) send_sample(random_sample());
        settle();

        // one result per sample: long receiver hold-off, then a full drain
        write_geometry(imp2x2_pkg::MODE_STRIDE1, 1, 1, 3);
        for (int i = 0; i < 40; i++) begin
            if (i == 5) hold_requests <= hold_requests + 1;
            if (i == 25) drain();
            random_items++;
            send_sample(random_sample());
        end

        while (random_items < RANDOM_ITEMS) begin
            m    = 1'($urandom_range(1));
            w    = $urandom_range(1, 5);
            h    = $urandom_range(1, 4);
            nc   = $urandom_range(1, 3);
            pick = $urandom_range(99);
            if (pick < 70) begin
                n = ($urandom_range(3) == 0) ? $urandom_range(1, w * h * nc)
                                             : w * h * nc * $urandom_range(1, 2);
            end else if (pick < 85) begin
                case ($urandom_range(3))
                    0: begin
                        w  = 32'(imp2x2_pkg::MAX_DIM);
                        nc = STORE_DEPTH / 32'(imp2x2_pkg::MAX_DIM);
                        h  = $urandom_range(1, 1024);
                    end
                    1: begin
                        w  = STORE_DEPTH / 32'(imp2x2_pkg::MAX_NCH);
                        nc = 32'(imp2x2_pkg::MAX_NCH);
                    end
                    2: begin
                        w  = 1;
                        nc = 32'(imp2x2_pkg::MAX_NCH);
                        h  = 32'(imp2x2_pkg::MAX_DIM);
                    end
                    default: begin
                        h  = 32'(imp2x2_pkg::MAX_DIM);
                        nc = 1;
                    end
                endcase
                n = $urandom_range(8, 20);
            end else begin
                case ($urandom_range(6))
                    0: w = 0;
                    1: w = $urandom_range(2047, 1025);
                    2: h = 0;
                    3: h = $urandom_range(2047, 1025);
                    4: nc = 0;
                    5: nc = $urandom_range(511, 257);
                    default: begin
                        w  = 32'(imp2x2_pkg::MAX_DIM);
                        nc = STORE_DEPTH / 32'(imp2x2_pkg::MAX_DIM) + 1;
                    end
                endcase
                n = $urandom_range(3, 6);
            end
            settle();
            write_geometry(m, w, h, nc);
            if ($urandom_range(3) == 0) write_unused_reg();
            run_samples(n);
        end

        settle();
        if (sb.errors == 0 && sb.pooled_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ int8_max_pool_2x2.f @@
src/imp2x2_pkg.sv
src/int8_max_pool_2x2.sv
sim/tb.sv
